@@ design/gpm_pkg.sv @@
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared types, codes and constants of the controller I/O port multiplexer.
// ----------------------------------------------------------------------------
package gpm_pkg;

  // Operation codes carried in the op field of an input item.
  localparam logic [2:0] OP_DATA_RD = 3'd0;
  localparam logic [2:0] OP_DATA_WR = 3'd1;
  localparam logic [2:0] OP_CTRL_RD = 3'd2;
  localparam logic [2:0] OP_CTRL_WR = 3'd3;
  localparam logic [2:0] OP_FRAME   = 3'd4;

  // Attached device codes.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PAD3 = 2'd1;
  localparam logic [1:0] KIND_PAD6 = 2'd2;

  // Bit positions within the buttons field.
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;
  localparam int unsigned BTN_A     = 4;
  localparam int unsigned BTN_B     = 5;
  localparam int unsigned BTN_C     = 6;
  localparam int unsigned BTN_START = 7;
  localparam int unsigned BTN_X     = 8;
  localparam int unsigned BTN_Y     = 9;
  localparam int unsigned BTN_Z     = 10;

  // Pad encoding constants.
  localparam logic [7:0] PAD_IDLE      = 8'hFF;
  localparam logic [7:0] PAD_BASE_LOW  = 8'h4C;
  localparam logic [7:0] PAD_BASE_ID   = 8'h4F;
  localparam logic [7:0] PAD_BASE_EXT  = 8'h40;
  localparam logic [7:0] DRIVE_ALWAYS  = 8'h80;
  localparam logic [7:0] INPUT_MASK    = 8'h7F;
  localparam int unsigned TH_BIT       = 6;

  // Six-button phases with a special encoding (stepped phase value).
  localparam logic [3:0] PHASE_ID  = 4'd6;
  localparam logic [3:0] PHASE_EXT = 4'd7;
  localparam logic [3:0] PHASE_END = 4'd8;

  // Configuration register index.
  localparam logic REG_DEVICE_KIND = 1'b0;

  // One port operation handed from the input stage to the port registers.
  typedef struct packed {
    logic        fire;
    logic [2:0]  op;
    logic [7:0]  write_value;
    logic [10:0] buttons;
  } port_cmd_t;

  // A write of the device kind register.
  typedef struct packed {
    logic       wr;
    logic [1:0] kind;
  } cfg_wr_t;

endpackage

@@ design/gamepad_io_port_mux.sv @@
// ----------------------------------------------------------------------------
// gamepad_io_port_mux
// One controller I/O port with a control register, an output latch and an
// attached pad (none, three-button or six-button), driven by a stream of
// port operations.
// ----------------------------------------------------------------------------
// Each input item is one port operation. It is taken into an input register,
// executed against the port state once it is free to advance and, for a data read
// or a control read, its byte is placed in the result register. One item is
// accepted every cycle; the only thing that holds the input side back is a
// read whose result cannot be stored because the previous result is still
// waiting to be taken. Writes, control writes and frame ends produce no
// result. The device kind is set through the configuration port, and writing
// it also clears the select line and the six-button read phase.
module gamepad_io_port_mux (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields from bit 0: op[2:0], write_value[10:3], buttons[21:11],
  // zero fill [23:22].
  input  logic [23:0] s_tdata,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields from bit 0: read_value[7:0].
  output logic [7:0]  m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Input register.
  logic        in_valid;
  logic [2:0]  in_op;
  logic [7:0]  in_write_value;
  logic [10:0] in_buttons;

  logic        in_produces;
  logic        advance;
  logic [1:0]  device_kind;
  logic [7:0]  read_value;

  gpm_pkg::port_cmd_t cmd;
  gpm_pkg::cfg_wr_t   cfg;

  // Only data and control reads return a byte.
  assign in_produces = (in_op == gpm_pkg::OP_DATA_RD) || (in_op == gpm_pkg::OP_CTRL_RD);

  // The held item executes unless it needs the result register and that
  // register is still full and stalled.
  assign advance  = in_valid && (!in_produces || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
    end
    if (s_tready && s_tvalid) begin
      in_op          <= s_tdata[2:0];
      in_write_value <= s_tdata[10:3];
      in_buttons     <= s_tdata[21:11];
    end
  end

  always_comb begin
    cmd.fire        = advance;
    cmd.op          = in_op;
    cmd.write_value = in_write_value;
    cmd.buttons     = in_buttons;
  end

  // Configuration write decode: only the device kind register exists.
  assign pready = 1'b1;

  always_comb begin
    cfg.wr   = psel && penable && pwrite && (paddr[2] == gpm_pkg::REG_DEVICE_KIND);
    cfg.kind = pwdata[1:0];
  end

  assign prdata = (paddr[2] == gpm_pkg::REG_DEVICE_KIND) ? {30'd0, device_kind} : 32'd0;

  gpm_port_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .device_kind (device_kind),
    .read_value  (read_value)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_produces) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_produces) begin
      m_tdata <= read_value;
    end
  end

`ifndef SYNTH
  // An empty input register never refuses an item.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but not ready");

  // A read stalled behind an untaken result keeps the input side closed.
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_produces && m_tvalid && !m_tready) |-> !s_tready)
    else $error("read executed while result register was full");

  // An item without a result never leaves a result behind.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_produces && (!m_tvalid || m_tready)) |=> !m_tvalid)
    else $error("result produced by an operation that returns nothing");
`endif

endmodule

@@ design/gpm_pad_encode.sv @@
// ----------------------------------------------------------------------------
// gpm_pad_encode
// Active-low pad byte seen by the port for the attached device.
// ----------------------------------------------------------------------------
module gpm_pad_encode (
  input  logic [1:0]  device_kind,
  input  logic        select_line,
  input  logic [3:0]  phase,
  input  logic [10:0] buttons,
  output logic [7:0]  pad_value
);

  logic       six;
  logic       pad3;
  logic [7:0] code;

  always_comb begin
    six  = (device_kind == gpm_pkg::KIND_PAD6);
    pad3 = (device_kind == gpm_pkg::KIND_PAD3);
    code = 8'h00;
    if (select_line) begin
      code[5] = buttons[gpm_pkg::BTN_C];
      code[4] = buttons[gpm_pkg::BTN_B];
      if (six && (phase == gpm_pkg::PHASE_EXT)) begin
        code[2] = buttons[gpm_pkg::BTN_X];
        code[1] = buttons[gpm_pkg::BTN_Y];
        code[0] = buttons[gpm_pkg::BTN_Z];
      end else begin
        code[3] = buttons[gpm_pkg::BTN_RIGHT];
        code[2] = buttons[gpm_pkg::BTN_LEFT];
        code[1] = buttons[gpm_pkg::BTN_DOWN];
        code[0] = buttons[gpm_pkg::BTN_UP];
      end
    end else begin
      code[5] = buttons[gpm_pkg::BTN_START];
      code[4] = buttons[gpm_pkg::BTN_A];
      if (six && (phase == gpm_pkg::PHASE_END)) begin
        code = code | gpm_pkg::PAD_BASE_EXT;
      end else if (six && (phase == gpm_pkg::PHASE_ID)) begin
        code = code | gpm_pkg::PAD_BASE_ID;
      end else begin
        code    = code | gpm_pkg::PAD_BASE_LOW;
        code[1] = buttons[gpm_pkg::BTN_DOWN];
        code[0] = buttons[gpm_pkg::BTN_UP];
      end
    end
    pad_value = (six || pad3) ? ~code : gpm_pkg::PAD_IDLE;
  end

endmodule

@@ design/gpm_port_regs.sv @@
// ----------------------------------------------------------------------------
// gpm_port_regs
// Port state (control, latch, select line, read phase, device kind) and the
// execution of one port operation per cycle while no configuration write is made.
// ----------------------------------------------------------------------------
module gpm_port_regs (
  input  logic                clk,
  input  logic                rst,
  input  gpm_pkg::port_cmd_t  cmd,
  input  gpm_pkg::cfg_wr_t    cfg,
  output logic [1:0]          device_kind,
  output logic [7:0]          read_value
);

  logic [7:0] direction_control;
  logic [7:0] output_latch;
  logic       select_line;
  logic [2:0] read_phase;
  logic [3:0] phase_step;
  logic [7:0] pad_value;
  logic       pad_present;

  // Six-button reads look at the phase after stepping.
  assign phase_step  = {1'b0, read_phase} + 4'd1;
  assign pad_present = (device_kind == gpm_pkg::KIND_PAD3) ||
                       (device_kind == gpm_pkg::KIND_PAD6);

  gpm_pad_encode u_encode (
    .device_kind (device_kind),
    .select_line (select_line),
    .phase       (phase_step),
    .buttons     (cmd.buttons),
    .pad_value   (pad_value)
  );

  always_comb begin
    if (cmd.op == gpm_pkg::OP_CTRL_RD) begin
      read_value = direction_control;
    end else begin
      read_value = ((direction_control | gpm_pkg::DRIVE_ALWAYS) & output_latch) |
                   (~direction_control & gpm_pkg::INPUT_MASK & pad_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_kind       <= gpm_pkg::KIND_NONE;
      direction_control <= 8'h00;
      output_latch      <= 8'h00;
      select_line       <= 1'b0;
      read_phase        <= 3'd0;
    end else if (cfg.wr) begin
      device_kind <= cfg.kind;
      select_line <= 1'b0;
      read_phase  <= 3'd0;
    end else if (cmd.fire) begin
      unique case (cmd.op)
        gpm_pkg::OP_DATA_RD: begin
          // The phase counter wraps from the eighth read back to zero.
          if (device_kind == gpm_pkg::KIND_PAD6) begin
            read_phase <= phase_step[2:0];
          end
        end
        gpm_pkg::OP_DATA_WR: begin
          output_latch <= cmd.write_value;
          if (pad_present) begin
            select_line <= cmd.write_value[gpm_pkg::TH_BIT] &
                           direction_control[gpm_pkg::TH_BIT];
          end
        end
        gpm_pkg::OP_CTRL_WR: begin
          direction_control <= cmd.write_value;
        end
        gpm_pkg::OP_FRAME: begin
          read_phase <= 3'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ bench/gamepad_io_port_mux_test.sv @@
// ----------------------------------------------------------------------------
// gamepad_io_port_mux_test
// Self-checking bench for the controller I/O port: directed accesses, then
// random pad polling sequences under several device kinds, checked item by
// item against a behavioural model of the port held in the bench.
// ----------------------------------------------------------------------------
module gamepad_io_port_mux_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Device code with no pad behind it, and one of the op codes that the port
  // ignores.
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_CYCLES     = 64;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 300000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // s_tdata fields from bit 0: op[2:0], write_value[10:3], buttons[21:11],
  // zero fill [23:22].
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // m_tdata fields from bit 0: read_value[7:0].
  logic [7:0]  m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gamepad_io_port_mux i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the port state. It is advanced in the order in which items
  // are accepted, and every read that it answers leaves one byte in
  // read_bytes_due for the result monitor to compare against.
  // --------------------------------------------------------------------------
  logic [1:0] pad_kind;
  logic [7:0] ctl_dir;
  logic [7:0] out_latch;
  logic       th_level;
  logic [3:0] pad_phase;
  logic [7:0] read_bytes_due[$];

  int  fail_count;
  int  items_sent;
  int  cycle_count;
  bit  idle_on;
  bit  hold_long;

  // Active-low lines that the pad presents for the current select level. On
  // the six-button pad the stepped phase picks the identification and the
  // extra-button encodings.
  function automatic logic [7:0] pad_lines(input logic [10:0] btn,
                                           input logic [3:0] phase,
                                           input logic six);
    logic [7:0] code;
    if (th_level) begin
      code = {2'b00, btn[gpm_pkg::BTN_C], btn[gpm_pkg::BTN_B], 4'b0000};
      if (six && phase == gpm_pkg::PHASE_EXT) begin
        code[2:0] = {btn[gpm_pkg::BTN_X], btn[gpm_pkg::BTN_Y], btn[gpm_pkg::BTN_Z]};
      end else begin
        code[3:0] = {btn[gpm_pkg::BTN_RIGHT], btn[gpm_pkg::BTN_LEFT],
                     btn[gpm_pkg::BTN_DOWN], btn[gpm_pkg::BTN_UP]};
      end
    end else begin
      code = {2'b00, btn[gpm_pkg::BTN_START], btn[gpm_pkg::BTN_A], 4'b0000};
      if (six && phase == gpm_pkg::PHASE_END) begin
        code = code | gpm_pkg::PAD_BASE_EXT;
      end else if (six && phase == gpm_pkg::PHASE_ID) begin
        code = code | gpm_pkg::PAD_BASE_ID;
      end else begin
        code = code | gpm_pkg::PAD_BASE_LOW |
               {6'b0, btn[gpm_pkg::BTN_DOWN], btn[gpm_pkg::BTN_UP]};
      end
    end
    return ~code;
  endfunction

  // Applies one accepted item to the bench state and gives the byte that a
  // read returns.
  task automatic port_access(input logic [2:0] op, input logic [7:0] wv,
                             input logic [10:0] btn, output logic yields,
                             output logic [7:0] rd_val);
    logic [7:0] lines;
    logic [3:0] stepped;
    yields = 1'b0;
    rd_val = 8'h00;
    case (op)
      gpm_pkg::OP_DATA_RD: begin
        if (pad_kind == gpm_pkg::KIND_PAD3) begin
          lines = pad_lines(btn, 4'd0, 1'b0);
        end else if (pad_kind == gpm_pkg::KIND_PAD6) begin
          stepped   = {1'b0, pad_phase[2:0]} + 4'd1;
          lines     = pad_lines(btn, stepped, 1'b1);
          pad_phase = (stepped == gpm_pkg::PHASE_END) ? 4'd0 : stepped;
        end else begin
          lines = gpm_pkg::PAD_IDLE;
        end
        yields = 1'b1;
        rd_val = ((ctl_dir | gpm_pkg::DRIVE_ALWAYS) & out_latch) |
                 (~ctl_dir & gpm_pkg::INPUT_MASK & lines);
      end
      gpm_pkg::OP_DATA_WR: begin
        if (pad_kind == gpm_pkg::KIND_PAD3 || pad_kind == gpm_pkg::KIND_PAD6) begin
          th_level = wv[gpm_pkg::TH_BIT] & ctl_dir[gpm_pkg::TH_BIT];
        end
        out_latch = wv;
      end
      gpm_pkg::OP_CTRL_RD: begin
        yields = 1'b1;
        rd_val = ctl_dir;
      end
      gpm_pkg::OP_CTRL_WR: begin
        ctl_dir = wv;
      end
      gpm_pkg::OP_FRAME: begin
        pad_phase = 4'd0;
      end
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Clock, and the watchdog that ends a run which has stopped making progress.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gamepad_io_port_mux_test: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side. The receiver stalls in short random bursts while idling is
  // enabled, and once holds off for a long stretch on request so that the
  // port fills up and has to back-pressure its input.
  // --------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_long = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Every result taken is matched against the oldest byte still due.
  logic [7:0] due_val;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (read_bytes_due.size() == 0) begin
        $error("read_value: expected no item, got %02h", m_tdata);
        fail_count++;
      end else begin
        due_val = read_bytes_due.pop_front();
        if (m_tdata !== due_val) begin
          $error("read_value: expected %02h, got %02h", due_val, m_tdata);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. An item is presented at a falling edge and counted as taken
  // at the first rising edge that sees s_tready high. tvalid stays high
  // between items unless a random gap is inserted.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [2:0] op, input logic [7:0] wv,
                           input logic [10:0] btn, input logic typed = 1'b0,
                           input logic [7:0] want = 8'h00);
    logic       yields;
    logic [7:0] rd_val;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, btn, wv, op};
    do @(posedge clk); while (!s_tready);
    port_access(op, wv, btn, yields, rd_val);
    if (yields) begin
      read_bytes_due.push_back(typed ? want : rd_val);
    end
    if (op <= gpm_pkg::OP_FRAME) begin
      items_sent++;
    end
  endtask

  // Stops offering items and waits until every expected byte has come back.
  task automatic drain_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Sets the device kind with the port idle. A write or frame end may still
  // sit in the pipeline after the last result, so a few cycles are allowed
  // to pass first. The register is read back straight after the write.
  task automatic set_device_kind(input logic [1:0] kind);
    drain_input();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * gpm_pkg::REG_DEVICE_KIND);
    pwdata  <= {30'b0, kind};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pad_kind  = kind;
    th_level  = 1'b0;
    pad_phase = 4'd0;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {30'b0, kind}) begin
      $error("device_kind: expected %0h, got %0h", kind, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One poll of the pad as a game would do it: perhaps set the direction
  // register, usually with the select line as an output, perhaps mark a frame end,
  // then toggle the select line and read after each toggle. The contents of
  // every field are random apart from the select bit.
  task automatic poll_burst(input bit quiet);
    logic [7:0] wv;
    int         pairs;
    idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 2) == 0) begin
      wv = 8'($urandom);
      if ($urandom_range(0, 4) != 0) begin
        wv[gpm_pkg::TH_BIT] = 1'b1;
      end
      send_item(gpm_pkg::OP_CTRL_WR, wv, 11'($urandom));
    end
    if ($urandom_range(0, 1) == 0) begin
      send_item(gpm_pkg::OP_FRAME, 8'($urandom), 11'($urandom));
    end
    pairs = $urandom_range(1, 4);
    repeat (pairs) begin
      wv = 8'($urandom);
      wv[gpm_pkg::TH_BIT] = 1'b1;
      send_item(gpm_pkg::OP_DATA_WR, wv, 11'($urandom));
      send_item(gpm_pkg::OP_DATA_RD, 8'($urandom), 11'($urandom));
      wv = 8'($urandom);
      wv[gpm_pkg::TH_BIT] = 1'b0;
      send_item(gpm_pkg::OP_DATA_WR, wv, 11'($urandom));
      send_item(gpm_pkg::OP_DATA_RD, 8'($urandom), 11'($urandom));
      if ($urandom_range(0, 5) == 0) begin
        send_item(gpm_pkg::OP_CTRL_RD, 8'($urandom), 11'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed script. A row either sets the device kind (the kind is carried
  // in wv) or sends one item; the expected byte is typed in only where it is
  // plain from the state, otherwise the bench model supplies it.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  op;
    logic [7:0]  wv;
    logic [10:0] btn;
    logic        typed;
    logic [7:0]  want;
  } script_row_t;

  localparam int SCRIPT_LEN = 32;

  script_row_t script [SCRIPT_LEN] = '{
    // No device: the control register reads zero after reset and the pad
    // lines float high.
    '{1'b0, gpm_pkg::OP_CTRL_RD, 8'h00, 11'h000, 1'b1, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h000, 1'b1, 8'h7F},
    // Latch all ones: bit 7 is always driven from the latch.
    '{1'b0, gpm_pkg::OP_DATA_WR, 8'hFF, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b1, 8'hFF},
    // Every pin an output, bit 7 of the control register included.
    '{1'b0, gpm_pkg::OP_CTRL_WR, 8'hFF, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_CTRL_RD, 8'h00, 11'h000, 1'b1, 8'hFF},
    '{1'b0, gpm_pkg::OP_DATA_WR, 8'h00, 11'h7FF, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'hFF, 11'h7FF, 1'b1, 8'h00},
    // Only the select line is an output from here on.
    '{1'b0, gpm_pkg::OP_CTRL_WR, 8'h40, 11'h000, 1'b0, 8'h00},
    // Three-button pad, select high then low, all and alternate buttons.
    '{1'b1, 3'd0,                8'(gpm_pkg::KIND_PAD3), 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_WR, 8'hC0, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_WR, 8'h00, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h2AA, 1'b0, 8'h00},
    // A reserved op code changes nothing and returns nothing.
    '{1'b0, OP_RSVD_LAST,        8'hFF, 11'h7FF, 1'b0, 8'h00},
    // Six-button pad: six reads with select low reach the identification
    // phase, then one high read gives the extra buttons and the eighth low
    // read the end-of-cycle code.
    '{1'b1, 3'd0,                8'(gpm_pkg::KIND_PAD6), 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h555, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h2AA, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_WR, 8'h40, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_WR, 8'h00, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00},
    // The counter wraps; a frame end brings it back to the start as well.
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h0F0, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_FRAME,   8'h00, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00},
    // The spare device code behaves as no device.
    '{1'b1, 3'd0,                8'(KIND_UNUSED), 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_WR, 8'h40, 11'h000, 1'b0, 8'h00},
    '{1'b0, gpm_pkg::OP_DATA_RD, 8'h00, 11'h7FF, 1'b0, 8'h00}
  };

  // Device kind for each random phase; the last phase runs without idling.
  logic [1:0] kind_plan [NUM_PHASES] = '{
    gpm_pkg::KIND_PAD6, gpm_pkg::KIND_PAD3, KIND_UNUSED, gpm_pkg::KIND_NONE,
    gpm_pkg::KIND_PAD6, gpm_pkg::KIND_PAD6
  };

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int target;
    bit hold_done;
    bit pause_done;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    items_sent  = 0;
    idle_on     = 1'b1;
    hold_long   = 1'b0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    pad_kind    = gpm_pkg::KIND_NONE;
    ctl_dir     = 8'h00;
    out_latch   = 8'h00;
    th_level    = 1'b0;
    pad_phase   = 4'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        set_device_kind(script[i].wv[1:0]);
      end else begin
        send_item(script[i].op, script[i].wv, script[i].btn, script[i].typed,
                  script[i].want);
      end
    end

    // Random part. Mostly well-formed poll sequences, with unconstrained
    // items mixed in, reserved op codes among them.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_device_kind(kind_plan[ph]);
      if (ph == NUM_PHASES - 1) begin
        idle_on = 1'b0;
      end
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        // Hold the result side off while reads keep coming, so that the
        // port fills up and stalls its input.
        if (ph == 1 && !hold_done && items_sent >= target - 60) begin
          hold_done = 1'b1;
          hold_long = 1'b1;
          idle_on   = 1'b0;
          repeat (24) send_item(gpm_pkg::OP_DATA_RD, 8'($urandom), 11'($urandom));
        end
        // Let the port run completely dry once in the middle of a phase.
        if (ph == 2 && !pause_done && items_sent >= target - 60) begin
          pause_done = 1'b1;
          drain_input();
        end
        if ($urandom_range(0, 9) < 7) begin
          poll_burst(ph == NUM_PHASES - 1);
        end else begin
          send_item(3'($urandom), 8'($urandom), 11'($urandom));
        end
      end
    end

    drain_input();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("gamepad_io_port_mux_test: PASS");
    end else begin
      $display("gamepad_io_port_mux_test: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/gpm_pkg.sv
design/gpm_pad_encode.sv
design/gpm_port_regs.sv
design/gamepad_io_port_mux.sv
bench/gamepad_io_port_mux_test.sv
